// File: rtl/fwss_pkg.sv
// Package of shared types and constants for the frame window slot store.
package fwss_pkg;
  localparam int MaxSlots = 64;
  localparam int IdxW = 6;
  localparam int CapW = 7;
  localparam int SnapW = 64;
  localparam int InW = 32;
  localparam int FrameW = 32;
  localparam int EntW = FrameW + SnapW + InW + InW + 3;

  localparam logic [2:0] ModeSnap = 3'd0;
  localparam logic [2:0] ModeLocal = 3'd1;
  localparam logic [2:0] ModeRemote = 3'd2;
  localparam logic [2:0] ModeQuery = 3'd3;
  localparam logic [2:0] ModeEvict = 3'd4;

  localparam logic [0:0] RegCapacity = 1'b0;

  typedef struct packed {
    logic [2:0] mode;
    logic [FrameW-1:0] frame;
    logic [SnapW-1:0] snapshot_data;
    logic [InW-1:0] input_data;
    logic confirmed;
  } in_word_t;

  typedef struct packed {
    logic found;
    logic has_local;
    logic [InW-1:0] local_word;
    logic remote_ok;
    logic [InW-1:0] remote_word;
    logic inputs_agree;
    logic [SnapW-1:0] snapshot_out;
    logic [CapW-1:0] stored_count;
  } out_word_t;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [SnapW-1:0] snap;
    logic [InW-1:0] loc;
    logic [InW-1:0] rem;
    logic has_snap;
    logic has_local;
    logic remote_ok;
  } entry_t;
endpackage

// File: rtl/fwss_ram.sv
// Generic single-port synchronous RAM with registered read.
module fwss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/fwss_modu.sv
// Iterative unit that reduces a 32-bit frame modulo the capacity, one bit a cycle.
module fwss_modu import fwss_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FrameW-1:0] num,
  input  logic [CapW-1:0]   den,
  output logic              done,
  output logic [IdxW-1:0]   rem
);
  logic [CapW:0] rem_r;
  logic [FrameW-1:0] num_r;
  logic [5:0] cnt_r;
  logic busy_r;
  logic [CapW:0] sh;

  assign sh = {rem_r[CapW-1:0], num_r[FrameW-1]};
  assign rem = rem_r[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 6'd0;
        rem_r <= '0;
        num_r <= num;
      end else if (busy_r) begin
        num_r <= {num_r[FrameW-2:0], 1'b0};
        rem_r <= (sh >= {1'b0, den}) ? sh - {1'b0, den} : sh;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(FrameW - 1)) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/frame_window_slot_store.sv
// Top level: slot memory, window tracking and the operation sequencer.
// Words that address a slot go through the modulo unit, a slot read and the operation
// state; zero capacity, unused modes and evicting from an empty window go straight to the
// result. A snapshot store that trims the window reruns the modulo unit, then clears
// the trimmed slots in turn. One word at a time: the next word is taken in the cycle
// after the result is accepted. Reset or a capacity write clears the slot memory and window.
module frame_window_slot_store import fwss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MOD, S_RD, S_OP, S_ESTART, S_EMOD, S_ECLR, S_OUT
  } state_t;

  state_t state_r;
  logic [CapW-1:0] cap_r;
  logic [FrameW-1:0] old_r, new_r, ework_r;
  logic win_r;
  in_word_t item_r;
  out_word_t out_r;
  logic [IdxW-1:0] idx_r, fidx_r, clr_r;
  logic [CapW-1:0] excess_r;
  logic mstart;
  logic [FrameW-1:0] mnum;
  logic mdone;
  logic [IdxW-1:0] mrem;
  logic we;
  logic [IdxW-1:0] addr;
  entry_t wdata, rdata;
  logic cfg_wr;
  in_word_t item_nxt;
  out_word_t out_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {25'd0, cap_r};
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == RegCapacity);
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = out_r;

  fwss_modu u_mod (
    .clk(clk), .rst_n(rst_n), .start(mstart), .num(mnum), .den(cap_r),
    .done(mdone), .rem(mrem)
  );

  fwss_ram #(.Width(EntW), .Depth(MaxSlots)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  function automatic logic [CapW-1:0] count_f(logic v, logic [FrameW-1:0] o,
                                              logic [FrameW-1:0] n);
    logic [32:0] d;
    d = {1'b0, n} - {1'b0, o} + 33'd1;
    if (!v) return '0;
    return (d > 33'd127) ? 7'd127 : d[CapW-1:0];
  endfunction

  logic [FrameW-1:0] lo_n, hi_n;
  logic [32:0] span;
  logic [32:0] excess;
  logic hit;

  always_comb begin
    lo_n = (!win_r || item_r.frame < old_r) ? item_r.frame : old_r;
    hi_n = (!win_r || item_r.frame > new_r) ? item_r.frame : new_r;
    span = {1'b0, hi_n} - {1'b0, lo_n} + 33'd1;
    excess = span - {26'd0, cap_r};
    hit = win_r && item_r.frame >= old_r && item_r.frame <= new_r &&
          rdata.has_snap && rdata.frame == item_r.frame;
  end

  always_comb begin
    item_nxt = in_data;
    if (in_data.mode == ModeEvict) item_nxt.frame = old_r;
    out_nxt = '0;
    out_nxt.stored_count = (cap_r == 0) ? '0 : count_f(win_r, old_r, new_r);
  end

  always_comb begin
    mstart = 1'b0;
    mnum = item_r.frame;
    we = 1'b0;
    addr = idx_r;
    wdata = rdata;
    case (state_r)
      S_IDLE: begin
        mnum = in_data.frame;
        mstart = in_valid && cap_r != 0 && in_data.mode <= ModeEvict &&
                 !(in_data.mode == ModeEvict && !win_r) && !cfg_wr;
        if (in_data.mode == ModeEvict) mnum = old_r;
      end
      S_CLR: begin
        we = 1'b1;
        addr = clr_r;
        wdata = '0;
      end
      S_OP: begin
        case (item_r.mode)
          ModeSnap: begin
            we = 1'b1;
            wdata.frame = item_r.frame;
            wdata.snap = item_r.snapshot_data;
            wdata.has_snap = 1'b1;
          end
          ModeLocal: begin
            we = 1'b1;
            wdata.frame = item_r.frame;
            wdata.loc = item_r.input_data;
            wdata.has_local = 1'b1;
          end
          ModeRemote: begin
            we = 1'b1;
            wdata.frame = item_r.frame;
            wdata.rem = item_r.input_data;
            wdata.remote_ok = item_r.confirmed;
          end
          ModeEvict: begin
            we = hit;
            wdata = '0;
          end
          default: ;
        endcase
      end
      S_ESTART: begin
        mstart = 1'b1;
        mnum = ework_r;
      end
      S_ECLR: begin
        we = (idx_r != fidx_r);
        wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cap_r <= '0;
      win_r <= 1'b0;
      old_r <= '0;
      new_r <= '0;
      clr_r <= '0;
    end else begin
      if (cfg_wr) begin
        cap_r <= (cfg_pwdata[6:0] > 7'(MaxSlots)) ? 7'(MaxSlots) : cfg_pwdata[6:0];
        win_r <= 1'b0;
        old_r <= '0;
        new_r <= '0;
        clr_r <= '0;
        state_r <= S_CLR;
      end else begin
        unique case (state_r)
          S_CLR: begin
            clr_r <= clr_r + 1'b1;
            if (clr_r == IdxW'(MaxSlots - 1)) state_r <= S_IDLE;
          end
          S_IDLE: if (in_valid) begin
            item_r <= item_nxt;
            out_r <= out_nxt;
            if (mstart) state_r <= S_MOD;
            else state_r <= S_OUT;
          end
          S_MOD: if (mdone) begin
            idx_r <= mrem;
            fidx_r <= mrem;
            state_r <= S_RD;
          end
          S_RD: state_r <= S_OP;
          S_OP: begin
            state_r <= S_OUT;
            case (item_r.mode)
              ModeSnap: begin
                win_r <= 1'b1;
                if (span > {26'd0, cap_r}) begin
                  excess_r <= (excess >= {26'd0, cap_r}) ? cap_r : excess[CapW-1:0];
                  old_r <= lo_n + excess[FrameW-1:0];
                  ework_r <= lo_n;
                  state_r <= S_ESTART;
                end else old_r <= lo_n;
                new_r <= hi_n;
                out_r.stored_count <= count_f(1'b1, lo_n, hi_n) > cap_r ?
                                      cap_r : count_f(1'b1, lo_n, hi_n);
              end
              ModeQuery: if (hit) begin
                out_r.found <= 1'b1;
                out_r.has_local <= rdata.has_local;
                out_r.local_word <= rdata.has_local ? rdata.loc : '0;
                out_r.remote_ok <= rdata.remote_ok;
                out_r.remote_word <= rdata.remote_ok ? rdata.rem : '0;
                out_r.inputs_agree <= rdata.has_local && rdata.remote_ok &&
                                      rdata.loc == rdata.rem;
                out_r.snapshot_out <= rdata.snap;
              end
              ModeEvict: begin
                if (hit) begin
                  out_r.found <= 1'b1;
                  out_r.snapshot_out <= rdata.snap;
                end
                if (old_r == new_r) begin
                  win_r <= 1'b0;
                  old_r <= '0;
                  new_r <= '0;
                  out_r.stored_count <= '0;
                end else begin
                  old_r <= old_r + 32'd1;
                  out_r.stored_count <= count_f(1'b1, old_r + 32'd1, new_r);
                end
              end
              default: ;
            endcase
          end
          S_ESTART: state_r <= S_EMOD;
          S_EMOD: if (mdone) begin
            idx_r <= mrem;
            state_r <= S_ECLR;
          end
          S_ECLR: begin
            excess_r <= excess_r - 7'd1;
            idx_r <= ({1'b0, idx_r} == cap_r - 7'd1) ? '0 : idx_r + 6'd1;
            if (excess_r == 7'd1) state_r <= S_OUT;
          end
          S_OUT: if (!out_stall) state_r <= S_IDLE;
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end
endmodule

// File: rtl/fwss_checker.sv
// Port-level checker for the frame window slot store, bound to the top level.
module fwss_checker import fwss_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid) else $error("word accepted while a result waits");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inputs_agree |-> out_data.has_local && out_data.remote_ok)
    else $error("agreement without both inputs");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.stored_count <= 7'(MaxSlots))
    else $error("stored count above capacity");
endmodule

bind frame_window_slot_store fwss_checker u_fwss_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// File: verif/frame_window_slot_store_check.sv
// Checker for the frame window slot store: predicts each result word and compares it.
`timescale 1ns / 100ps
module frame_window_slot_store_check import fwss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_word_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  logic [CapW-1:0] cap;
  logic [FrameW-1:0] slot_fr [MaxSlots];
  logic [SnapW-1:0] slot_snap [MaxSlots];
  logic [InW-1:0] slot_loc [MaxSlots];
  logic [InW-1:0] slot_rem [MaxSlots];
  logic slot_hs [MaxSlots];
  logic slot_hl [MaxSlots];
  logic slot_rok [MaxSlots];
  logic [FrameW-1:0] old_fr, new_fr;
  logic win_ok;
  out_word_t result_q[$];

  function automatic void wipe_slot(int i);
    slot_fr[i] = '0;
    slot_snap[i] = '0;
    slot_loc[i] = '0;
    slot_rem[i] = '0;
    slot_hs[i] = 1'b0;
    slot_hl[i] = 1'b0;
    slot_rok[i] = 1'b0;
  endfunction

  function automatic void wipe_store();
    for (int i = 0; i < MaxSlots; i++) wipe_slot(i);
    old_fr = '0;
    new_fr = '0;
    win_ok = 1'b0;
  endfunction

  function automatic logic [CapW-1:0] frames_held();
    logic [32:0] n;
    if (!win_ok || cap == 0) return '0;
    n = {1'b0, new_fr} - {1'b0, old_fr} + 33'd1;
    return (n > 33'd127) ? 7'd127 : n[CapW-1:0];
  endfunction

  function automatic logic slot_hit(logic [31:0] f, output int idx);
    idx = 0;
    if (cap == 0 || !win_ok) return 1'b0;
    if (f < old_fr || f > new_fr) return 1'b0;
    idx = f % cap;
    return slot_hs[idx] && slot_fr[idx] == f;
  endfunction

  function automatic void keep_snapshot(logic [31:0] f, logic [63:0] d);
    logic [32:0] span, excess;
    int fidx, e;
    fidx = f % cap;
    if (!win_ok) begin
      old_fr = f;
      new_fr = f;
      win_ok = 1'b1;
    end else begin
      if (f < old_fr) old_fr = f;
      if (f > new_fr) new_fr = f;
    end
    span = {1'b0, new_fr} - {1'b0, old_fr} + 33'd1;
    if (span > cap) begin
      excess = span - cap;
      if (excess >= cap) begin
        for (int i = 0; i < cap; i++) if (i != fidx) wipe_slot(i);
      end else begin
        for (int k = 0; k < excess; k++) begin
          e = (old_fr + 32'(k)) % cap;
          if (e != fidx) wipe_slot(e);
        end
      end
      old_fr = old_fr + excess[31:0];
    end
    slot_fr[fidx] = f;
    slot_snap[fidx] = d;
    slot_hs[fidx] = 1'b1;
  endfunction

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    int s;
    r = '0;
    if (cap != 0) begin
      case (w.mode)
        ModeSnap: keep_snapshot(w.frame, w.snapshot_data);
        ModeLocal, ModeRemote: begin
          s = w.frame % cap;
          slot_fr[s] = w.frame;
          if (w.mode == ModeLocal) begin
            slot_loc[s] = w.input_data;
            slot_hl[s] = 1'b1;
          end else begin
            slot_rem[s] = w.input_data;
            slot_rok[s] = w.confirmed;
          end
        end
        ModeQuery: begin
          if (slot_hit(w.frame, s)) begin
            r.found = 1'b1;
            r.has_local = slot_hl[s];
            r.local_word = slot_hl[s] ? slot_loc[s] : '0;
            r.remote_ok = slot_rok[s];
            r.remote_word = slot_rok[s] ? slot_rem[s] : '0;
            r.inputs_agree = slot_hl[s] && slot_rok[s] && slot_loc[s] == slot_rem[s];
            r.snapshot_out = slot_snap[s];
          end
        end
        ModeEvict: begin
          if (win_ok) begin
            if (slot_hit(old_fr, s)) begin
              r.found = 1'b1;
              r.snapshot_out = slot_snap[s];
              wipe_slot(s);
            end
            if (old_fr == new_fr) begin
              win_ok = 1'b0;
              old_fr = '0;
              new_fr = '0;
            end else begin
              old_fr++;
            end
          end
        end
        default: ;
      endcase
    end
    r.stored_count = frames_held();
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    logic [6:0] v;
    if (!rst_n) begin
      cap = '0;
      wipe_store();
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[2] == RegCapacity) begin
        v = cfg_pwdata[6:0];
        wipe_store();
        cap = (v > MaxSlots) ? 7'(MaxSlots) : v;
      end
      if (in_valid && !in_stall) result_q.push_back(apply_word(in_data));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result word with no expectation waiting");
          fail_count++;
        end else begin
          e = result_q.pop_front();
          check_field("found", e.found, out_data.found);
          check_field("has_local", e.has_local, out_data.has_local);
          check_field("local_word", e.local_word, out_data.local_word);
          check_field("remote_ok", e.remote_ok, out_data.remote_ok);
          check_field("remote_word", e.remote_word, out_data.remote_word);
          check_field("inputs_agree", e.inputs_agree, out_data.inputs_agree);
          check_field("snapshot_out", e.snapshot_out, out_data.snapshot_out);
          check_field("stored_count", e.stored_count, out_data.stored_count);
        end
      end
    end
    pending = result_q.size();
  end
endmodule

// File: verif/frame_window_slot_store_test.sv
// Testbench top for the frame window slot store: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module frame_window_slot_store_test;
  import fwss_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int fail_count, pending;
  bit send_gaps, recv_gaps;
  logic [31:0] base_fr;
  int cap_now;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  frame_window_slot_store dut (.*);

  frame_window_slot_store_check checker_i (.*);

  initial begin
    #10ms;
    $display("** frame_window_slot_store: FAILED **");
    $finish;
  end

  initial begin
    int n;
    forever begin
      n = recv_gaps ? $urandom_range(0, 16) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = send_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_capacity(logic [31:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (200) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {RegCapacity, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cap_now = (v[6:0] > MaxSlots) ? MaxSlots : v[6:0];
  endtask

  function automatic in_word_t word_of(logic [2:0] m, logic [31:0] f, logic [63:0] s,
                                       logic [31:0] d, logic c);
    in_word_t w;
    w.mode = m;
    w.frame = f;
    w.snapshot_data = s;
    w.input_data = d;
    w.confirmed = c;
    return w;
  endfunction

  function automatic in_word_t random_word();
    int r, span;
    logic [2:0] m;
    logic [31:0] f, d;
    r = $urandom_range(0, 99);
    if (r < 35) m = ModeSnap;
    else if (r < 50) m = ModeLocal;
    else if (r < 65) m = ModeRemote;
    else if (r < 90) m = ModeQuery;
    else if (r < 97) m = ModeEvict;
    else m = 3'($urandom_range(5, 7));
    span = cap_now + 3;
    r = $urandom_range(0, 99);
    if (r < 80) f = base_fr + $urandom_range(0, span);
    else if (r < 92) f = base_fr - $urandom_range(0, 2 * span);
    else f = $urandom;
    if ($urandom_range(0, 3) == 0) base_fr = base_fr + $urandom_range(1, 3);
    d = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 2)) : $urandom;
    return word_of(m, f, {$urandom, $urandom}, d, $urandom_range(0, 3) != 0);
  endfunction

  initial begin
    int caps[8] = '{4, 0, 1, 64, 127, 3, 100, 17};
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    cap_now = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_capacity(caps[0]);
    send_word(word_of(ModeSnap, 32'd0, '1, '0, 1'b0));
    send_word(word_of(ModeLocal, 32'd0, '0, '1, 1'b0));
    send_word(word_of(ModeRemote, 32'd0, '0, '1, 1'b1));
    send_word(word_of(ModeQuery, 32'd0, '0, '0, 1'b0));
    send_word(word_of(ModeRemote, 32'd0, '0, 32'h5, 1'b0));
    send_word(word_of(ModeQuery, 32'd0, '0, '0, 1'b0));
    send_word(word_of(ModeSnap, 32'd1, 64'h1, '0, 1'b0));
    send_word(word_of(ModeSnap, 32'd6, 64'h6, '0, 1'b0));
    send_word(word_of(ModeSnap, 32'd2, 64'h2, '0, 1'b0));
    send_word(word_of(ModeQuery, 32'd2, '0, '0, 1'b0));
    send_word(word_of(ModeQuery, 32'd6, '0, '0, 1'b0));
    send_word(word_of(ModeEvict, 32'd0, '0, '0, 1'b0));
    send_word(word_of(ModeEvict, 32'd0, '0, '0, 1'b0));
    send_word(word_of(ModeSnap, 32'hFFFF_FFFF, '1, '0, 1'b0));
    send_word(word_of(ModeQuery, 32'hFFFF_FFFF, '0, '0, 1'b0));
    send_word(word_of(ModeQuery, 32'd6, '0, '0, 1'b0));
    for (int m = 5; m < 8; m++) send_word(word_of(3'(m), 32'd3, '1, '1, 1'b1));
    repeat (5) send_word(word_of(ModeEvict, 32'd0, '0, '0, 1'b0));

    foreach (caps[p]) begin
      if (p > 0) write_capacity(caps[p]);
      base_fr = (p % 3 == 2) ? 32'hFFFF_FFC0 : 32'($urandom_range(0, 1000));
      for (int i = 0; i < 236; i++) begin
        if (i % 60 == 0) begin
          send_gaps = $urandom_range(0, 2) != 0;
          recv_gaps = $urandom_range(0, 2) != 0;
        end
        send_word(random_word());
      end
    end
    write_capacity(32'd64);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** frame_window_slot_store: PASSED **");
    end else begin
      $display("** frame_window_slot_store: FAILED **");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/fwss_pkg.sv
rtl/fwss_ram.sv
rtl/fwss_modu.sv
rtl/frame_window_slot_store.sv
rtl/fwss_checker.sv
verif/frame_window_slot_store_check.sv
verif/frame_window_slot_store_test.sv
